// ===== src/fohe_pkg.sv =====
// Shared types, codes and lookup functions for the FASTA one-hot base encoder.
`default_nettype none

package fohe_pkg;

  // Character codes
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharHeader  = 8'h3E;  // '>'
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharLowA    = 8'h61;
  localparam logic [7:0] CharLowZ    = 8'h7A;
  localparam logic [7:0] CaseOffset  = 8'h20;
  localparam logic [7:0] CharA       = 8'h41;
  localparam logic [7:0] CharT       = 8'h54;
  localparam logic [7:0] CharC       = 8'h43;
  localparam logic [7:0] CharG       = 8'h47;

  // One-hot code anchors
  localparam logic [3:0]  SingleTop = 4'h8;
  localparam logic [15:0] PairTop   = 16'h8000;

  // Configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 1;
  localparam logic [CfgIdxW-1:0] CfgPairMode   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgComplement = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BASE   = 2'd0,
    KIND_RECORD = 2'd1,
    KIND_NAME   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] code;
    logic [7:0]  name_char;
  } res_t;

  // Upper-case only 'a'..'z'
  function automatic logic [7:0] upper_byte(input logic [7:0] c);
    if (c >= CharLowA && c <= CharLowZ) begin
      return c - CaseOffset;
    end
    return c;
  endfunction

  // Bit 2 flags an unknown symbol; bits 1:0 give the position in the base order
  function automatic logic [2:0] base_index(input logic [7:0] c, input logic inverse);
    logic [2:0] idx;
    case (c)
      CharA:   idx = inverse ? 3'd1 : 3'd0;
      CharT:   idx = inverse ? 3'd0 : 3'd1;
      CharC:   idx = inverse ? 3'd3 : 3'd2;
      CharG:   idx = inverse ? 3'd2 : 3'd3;
      default: idx = 3'd4;
    endcase
    return idx;
  endfunction

  function automatic logic [15:0] single_code(input logic [7:0] c, input logic inverse);
    logic [2:0] i;
    i = base_index(c, inverse);
    if (i[2]) begin
      return 16'h0000;
    end
    return {12'h000, SingleTop >> i[1:0]};
  endfunction

  function automatic logic [15:0] pair_code(input logic [7:0] first, input logic [7:0] second,
                                            input logic inverse);
    logic [2:0] i;
    logic [2:0] j;
    i = base_index(first, inverse);
    j = base_index(second, inverse);
    if (i[2] || j[2]) begin
      return 16'h0000;
    end
    return PairTop >> {i[1:0], j[1:0]};
  endfunction

endpackage

`default_nettype wire

// ===== src/fohe_if.sv =====
// Valid/ready channel interfaces for text input beats and result beats.
`default_nettype none

interface fohe_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface fohe_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] code;
  logic [7:0]  name_char;

  modport source (output valid, output kind, output code, output name_char, input ready);
  modport sink   (input valid, input kind, input code, input name_char, output ready);
endinterface

`default_nettype wire

// ===== src/fohe_parser.sv =====
// FASTA line parser: record state, configuration registers and base encoding.
`default_nettype none

module fohe_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [fohe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fohe_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                         accept_i,
  input  wire logic [7:0]                   char_i,
  output logic                              push_o,
  output fohe_pkg::res_t                    res_o
);
  import fohe_pkg::*;

  logic       pair_mode_q, complement_q;
  logic       line_start_q, line_start_d;
  logic       in_header_q, in_header_d;
  logic       name_ended_q, name_ended_d;
  logic       record_open_q, record_open_d;
  logic       have_prev_q, have_prev_d;
  logic [7:0] prev_char_q, prev_char_d;
  logic [7:0] up_char;
  logic       emit;

  assign up_char = upper_byte(char_i);

  // Classify the beat and build its result
  always_comb begin
    line_start_d  = line_start_q;
    in_header_d   = in_header_q;
    name_ended_d  = name_ended_q;
    record_open_d = record_open_q;
    have_prev_d   = have_prev_q;
    prev_char_d   = prev_char_q;
    emit          = 1'b0;
    res_o         = '{kind: KIND_BASE, code: 16'h0000, name_char: 8'h00};

    if (char_i == CharNewline) begin
      line_start_d = 1'b1;
      in_header_d  = 1'b0;
    end else if (line_start_q && char_i == CharHeader) begin
      line_start_d  = 1'b0;
      in_header_d   = 1'b1;
      name_ended_d  = 1'b0;
      record_open_d = 1'b1;
      have_prev_d   = 1'b0;
      prev_char_d   = 8'h00;
      emit          = 1'b1;
      res_o.kind    = KIND_RECORD;
    end else begin
      line_start_d = 1'b0;
      if (in_header_q) begin
        if (!name_ended_q) begin
          if (char_i == CharSpace || char_i == CharTab) begin
            name_ended_d = 1'b1;
          end else begin
            emit            = 1'b1;
            res_o.kind      = KIND_NAME;
            res_o.name_char = char_i;
          end
        end
      end else if (record_open_q) begin
        prev_char_d = up_char;
        have_prev_d = 1'b1;
        if (!pair_mode_q) begin
          emit       = 1'b1;
          res_o.code = single_code(up_char, complement_q);
        end else if (have_prev_q) begin
          emit       = 1'b1;
          res_o.code = pair_code(prev_char_q, up_char, complement_q);
        end
      end
    end
  end

  assign push_o = accept_i && emit;

  // Advance parser state on each accepted beat; take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_mode_q   <= 1'b1;
      complement_q  <= 1'b0;
      line_start_q  <= 1'b1;
      in_header_q   <= 1'b0;
      name_ended_q  <= 1'b0;
      record_open_q <= 1'b0;
      have_prev_q   <= 1'b0;
      prev_char_q   <= 8'h00;
    end else begin
      if (cfg_we_i && cfg_idx_i == CfgPairMode) begin
        pair_mode_q <= cfg_wdata_i[0];
      end
      if (cfg_we_i && cfg_idx_i == CfgComplement) begin
        complement_q <= cfg_wdata_i[0];
      end
      if (accept_i) begin
        line_start_q  <= line_start_d;
        in_header_q   <= in_header_d;
        name_ended_q  <= name_ended_d;
        record_open_q <= record_open_d;
        have_prev_q   <= have_prev_d;
        prev_char_q   <= prev_char_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/fohe_out_buf.sv =====
// Two-entry result buffer that decouples the output handshake from the parser.
`default_nettype none

module fohe_out_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire fohe_pkg::res_t res_i,
  output logic                space_o,
  output logic                valid_o,
  input  wire logic           ready_i,
  output fohe_pkg::res_t      res_o
);
  import fohe_pkg::*;

  res_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign valid_o = count_q != 2'd0;
  assign space_o = count_q != 2'd2;
  assign pop     = valid_o && ready_i;
  assign res_o   = slot_q[rd_ptr_q];

  // Store pushed results
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/fasta_onehot_base_encoder_core.sv =====
// Top level of the FASTA one-hot base encoder.
// Each result beat is registered in the two-entry result buffer before it is driven out.
// Throughput: one text beat per cycle; the two-entry result buffer keeps input
// open while one result waits, and input stalls only when both entries are full.
// Reset: asynchronous, active low; clears parser state and buffer, sets pair mode.
`default_nettype none

module fasta_onehot_base_encoder_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [fohe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [fohe_pkg::CfgDataW-1:0] cfg_wdata_i,
  fohe_char_if.sink                         chr_i,
  fohe_res_if.source                        res_o
);
  import fohe_pkg::*;

  logic accept;
  logic push;
  logic space;
  res_t parsed;
  res_t head;

  assign chr_i.ready = space;
  assign accept      = chr_i.valid && space;

  fohe_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .char_i      (chr_i.char_in),
    .push_o      (push),
    .res_o       (parsed)
  );

  fohe_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (parsed),
    .space_o (space),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .res_o   (head)
  );

  // Drive result beat payload
  assign res_o.kind      = head.kind;
  assign res_o.code      = head.code;
  assign res_o.name_char = head.name_char;

  // Base results carry at most one hot bit
  a_code_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind == KIND_BASE |-> $onehot0(res_o.code))
    else $error("base code has more than one bit set");

  // Record and name results carry no code
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind != KIND_BASE |-> res_o.code == 16'h0000)
    else $error("non-base result carries a code");

  // Input stalls only while results are waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !chr_i.ready |-> res_o.valid)
    else $error("input stalled with empty result buffer");

  // An accepted record-start byte leaves a result valid on the output next cycle
  a_record_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && parsed.kind == KIND_RECORD |=> res_o.valid)
    else $error("record start result lost");

endmodule

`default_nettype wire
